[rtl/fte_pkg.sv]
// fte_pkg: shared types and constants for the flow table idle expiry block
// no dependencies; imported by fte_front, fte_back and the top level

package fte_pkg;

	localparam int TIME_W    = 64;
	localparam int TIMEOUT_W = 40;
	localparam int CNT_W     = 13;
	localparam int LEN_W     = 16;
	localparam int KEY_W     = 96;
	localparam int DELTA_W   = 13;

	localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 40'd9000000;

	// len*8/100 == (2*len)/25, done as a reciprocal multiply with one correction step
	localparam int X_W         = LEN_W + 1;
	localparam int RECIP_W     = 16;
	localparam int PROD_W      = X_W + RECIP_W;
	localparam int RECIP_SHIFT = 20;
	localparam logic [RECIP_W-1:0] RECIP = 16'd41943;
	localparam logic [X_W-1:0] LINK_DIV = 17'd25;

	typedef struct packed {
		logic [31:0] src_addr;
		logic [31:0] dst_addr;
		logic [15:0] sport;
		logic [15:0] dport;
		logic [15:0] packet_length;
	} fte_in_t;

	typedef struct packed {
		logic              new_flow;
		logic              table_full;
		logic [CNT_W-1:0]  expired_count;
		logic [TIME_W-1:0] arrival_time;
	} fte_out_t;

	// front to back: flow key and the time step for this packet
	typedef struct packed {
		logic [KEY_W-1:0]   key;
		logic [DELTA_W-1:0] delta;
	} fte_work_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_EXP_RD,
		ST_EXP_CHK,
		ST_SRCH_CHK,
		ST_ALLOC,
		ST_INSERT,
		ST_HIT_W1,
		ST_HIT_W2,
		ST_DONE
	} fte_state_t;

endpackage

[rtl/fte_ram.sv]
// fte_ram: generic single write port, single read port ram with registered read
// no dependencies

module fte_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data <= mem[rd_addr];
	end

endmodule

[rtl/fte_fifo.sv]
// fte_fifo: two entry queue between the front and the back part
// no dependencies

module fte_fifo #(
	parameter int WIDTH = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_valid,
	output logic             wr_ready,
	input  logic [WIDTH-1:0] wr_data,
	output logic             rd_valid,
	input  logic             rd_ready,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] slot_q [2];
	logic             wp_q;
	logic             rp_q;
	logic [1:0]       cnt_q;
	logic             push;
	logic             pop;

	assign wr_ready = (cnt_q != 2'd2);
	assign rd_valid = (cnt_q != 2'd0);
	assign rd_data  = slot_q[rp_q];
	assign push     = wr_valid && wr_ready;
	assign pop      = rd_valid && rd_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wp_q <= ~wp_q;
			end
			if (pop) begin
				rp_q <= ~rp_q;
			end
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wp_q] <= wr_data;
		end
	end

endmodule

[rtl/fte_front.sv]
// fte_front: accepts packets, forms the flow key and the transmit time step
// depends on fte_pkg

module fte_front
	import fte_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  fte_in_t   in_data,
	output logic      work_valid,
	input  logic      work_ready,
	output fte_work_t work_data
);

	logic               v_s1;
	logic [KEY_W-1:0]   key_s1;
	logic [X_W-1:0]     x_s1;
	logic [PROD_W-1:0]  prod_s1;
	logic               v_s2;
	fte_work_t          work_s2;
	logic               adv_s1;
	logic               adv_s2;
	logic [DELTA_W-1:0] q0;
	logic [X_W-1:0]     rem;
	logic [DELTA_W-1:0] quot;

	assign adv_s2   = !v_s2 || work_ready;
	assign adv_s1   = !v_s1 || adv_s2;
	assign in_ready = adv_s1;

	// estimate is floor or one below, remainder stays under twice the divisor
	assign q0   = prod_s1[RECIP_SHIFT +: DELTA_W];
	assign rem  = x_s1 - X_W'(q0 * LINK_DIV);
	assign quot = (rem >= LINK_DIV) ? q0 + DELTA_W'(1) : q0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (adv_s1) begin
				v_s1 <= in_valid;
			end
			if (adv_s2) begin
				v_s2 <= v_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && in_valid) begin
			key_s1  <= {in_data.src_addr, in_data.dst_addr, in_data.sport,
				in_data.dport};
			x_s1    <= {in_data.packet_length, 1'b0};
			prod_s1 <= PROD_W'({in_data.packet_length, 1'b0}) * PROD_W'(RECIP);
		end
		if (adv_s2 && v_s1) begin
			work_s2.key   <= key_s1;
			work_s2.delta <= quot;
		end
	end

	assign work_valid = v_s2;
	assign work_data  = work_s2;

endmodule

[rtl/fte_back.sv]
// fte_back: flow table engine; expiry, lookup walk, refresh and insert
// depends on fte_pkg and fte_ram

module fte_back
	import fte_pkg::*;
#(
	parameter int TABLE_ENTRIES = 4096
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_wr_en,
	input  logic [TIMEOUT_W-1:0] cfg_wr_data,
	input  logic                 work_valid,
	output logic                 work_ready,
	input  fte_work_t            work_data,
	output logic                 out_valid,
	input  logic                 out_ready,
	output fte_out_t             out_data
);

	localparam int IW = $clog2(TABLE_ENTRIES);
	localparam int EW = KEY_W + TIME_W;
	localparam logic [IW:0] N_CNT = (IW+1)'(TABLE_ENTRIES);

	fte_state_t state_q, state_d;

	logic [TIMEOUT_W-1:0] timeout_q;
	logic [TIME_W-1:0]    cur_q;
	logic [TIME_W-1:0]    now_q;
	logic [KEY_W-1:0]     key_q;
	logic [CNT_W-1:0]     cnt_q;
	logic [IW:0]          occ_q;
	logic [IW:0]          fresh_q;
	logic [IW:0]          sp_q;
	logic [IW:0]          rem_q;
	logic [IW-1:0]        oldest_q;
	logic [IW-1:0]        newest_q;
	logic [IW-1:0]        e_q;
	logic [IW-1:0]        o_q;
	logic [IW-1:0]        n_q;
	logic                 res_new_q;
	logic                 res_full_q;
	logic                 out_valid_q;
	fte_out_t             out_q;

	logic [IW-1:0] rd_addr;
	logic [EW-1:0] ent_rd;
	logic [IW-1:0] nw_rd;
	logic [IW-1:0] od_rd;
	logic [IW-1:0] stk_rd;
	logic          ent_we;
	logic [IW-1:0] ent_wa;
	logic          nw_we;
	logic [IW-1:0] nw_wa;
	logic [IW-1:0] nw_wd;
	logic          od_we;
	logic [IW-1:0] od_wa;
	logic [IW-1:0] od_wd;
	logic          stk_we;

	logic          expired;
	logic          match;
	logic          full;
	logic          use_fresh;
	logic [IW-1:0] slot;
	logic          out_load;
	fte_state_t    miss_st;

	assign expired   = (now_q - ent_rd[TIME_W-1:0]) > TIME_W'(timeout_q);
	assign match     = (ent_rd[EW-1:TIME_W] == key_q);
	assign full      = (occ_q == N_CNT);
	assign use_fresh = (fresh_q < N_CNT);
	assign slot      = use_fresh ? fresh_q[IW-1:0] : stk_rd;
	assign miss_st   = full ? ST_DONE : ST_ALLOC;
	assign out_load  = (state_q == ST_DONE) && (!out_valid_q || out_ready);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (work_valid) state_d = ST_EXP_RD;
			end
			ST_EXP_RD: begin
				state_d = (occ_q == '0) ? miss_st : ST_EXP_CHK;
			end
			ST_EXP_CHK: begin
				if (expired) begin
					state_d = (occ_q == (IW+1)'(1)) ? ST_ALLOC : ST_EXP_CHK;
				end else if (match) begin
					state_d = ST_HIT_W1;
				end else if (occ_q == (IW+1)'(1)) begin
					state_d = miss_st;
				end else begin
					state_d = ST_SRCH_CHK;
				end
			end
			ST_SRCH_CHK: begin
				if (match) state_d = ST_HIT_W1;
				else if (rem_q == (IW+1)'(1)) state_d = miss_st;
			end
			ST_ALLOC:  state_d = ST_INSERT;
			ST_INSERT: state_d = ST_DONE;
			ST_HIT_W1: state_d = (e_q == newest_q) ? ST_DONE : ST_HIT_W2;
			ST_HIT_W2: state_d = ST_DONE;
			ST_DONE: begin
				if (!out_valid_q || out_ready) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// memory controls
	always_comb begin
		work_ready = (state_q == ST_IDLE);
		rd_addr    = oldest_q;
		ent_we     = 1'b0;
		ent_wa     = e_q;
		nw_we      = 1'b0;
		nw_wa      = newest_q;
		nw_wd      = e_q;
		od_we      = 1'b0;
		od_wa      = e_q;
		od_wd      = newest_q;
		stk_we     = 1'b0;
		unique case (state_q)
			ST_EXP_CHK: begin
				rd_addr = nw_rd;
				stk_we  = expired;
			end
			ST_SRCH_CHK: begin
				rd_addr = nw_rd;
			end
			ST_INSERT: begin
				ent_we = 1'b1;
				ent_wa = slot;
				nw_we  = (occ_q != '0);
				nw_wd  = slot;
				od_we  = (occ_q != '0);
				od_wa  = slot;
			end
			ST_HIT_W1: begin
				// refresh the entry and unlink it from the age list
				ent_we = 1'b1;
				nw_we  = (e_q != newest_q) && (e_q != oldest_q);
				nw_wa  = o_q;
				nw_wd  = n_q;
				od_we  = (e_q != newest_q);
				od_wa  = n_q;
				od_wd  = o_q;
			end
			ST_HIT_W2: begin
				nw_we = 1'b1;
				od_we = 1'b1;
			end
			ST_IDLE, ST_EXP_RD, ST_ALLOC, ST_DONE: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			timeout_q   <= TIMEOUT_RESET;
			cur_q       <= '0;
			occ_q       <= '0;
			fresh_q     <= '0;
			sp_q        <= '0;
			oldest_q    <= '0;
			newest_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_wr_en) begin
				timeout_q <= cfg_wr_data;
			end
			if (state_q == ST_IDLE && work_valid) begin
				cur_q <= cur_q + TIME_W'(work_data.delta);
			end
			if (state_q == ST_EXP_CHK && expired) begin
				sp_q     <= sp_q + (IW+1)'(1);
				oldest_q <= nw_rd;
				occ_q    <= occ_q - (IW+1)'(1);
			end
			if (state_q == ST_INSERT) begin
				occ_q    <= occ_q + (IW+1)'(1);
				newest_q <= slot;
				if (occ_q == '0) oldest_q <= slot;
				if (use_fresh) fresh_q <= fresh_q + (IW+1)'(1);
				else sp_q <= sp_q - (IW+1)'(1);
			end
			if (state_q == ST_HIT_W1 && e_q != newest_q && e_q == oldest_q) begin
				oldest_q <= n_q;
			end
			if (state_q == ST_HIT_W2) begin
				newest_q <= e_q;
			end
			if (out_load) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				now_q      <= cur_q + TIME_W'(work_data.delta);
				key_q      <= work_data.key;
				cnt_q      <= '0;
				res_new_q  <= 1'b0;
				res_full_q <= 1'b0;
			end
			ST_EXP_RD: begin
				e_q        <= oldest_q;
				res_full_q <= (occ_q == '0) && full;
			end
			ST_EXP_CHK: begin
				if (expired) begin
					cnt_q <= cnt_q + CNT_W'(1);
					e_q   <= nw_rd;
				end else if (match) begin
					o_q <= od_rd;
					n_q <= nw_rd;
				end else begin
					e_q        <= nw_rd;
					rem_q      <= occ_q - (IW+1)'(1);
					res_full_q <= (occ_q == (IW+1)'(1)) && full;
				end
			end
			ST_SRCH_CHK: begin
				if (match) begin
					o_q <= od_rd;
					n_q <= nw_rd;
				end else begin
					e_q        <= nw_rd;
					rem_q      <= rem_q - (IW+1)'(1);
					res_full_q <= (rem_q == (IW+1)'(1)) && full;
				end
			end
			ST_INSERT: res_new_q <= 1'b1;
			ST_ALLOC, ST_HIT_W1, ST_HIT_W2, ST_DONE: begin
			end
			default: begin
			end
		endcase
		if (out_load) begin
			out_q.new_flow      <= res_new_q;
			out_q.table_full    <= res_full_q;
			out_q.expired_count <= cnt_q;
			out_q.arrival_time  <= now_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	fte_ram #(.WIDTH(EW), .DEPTH(TABLE_ENTRIES)) u_entry (
		.clk     (clk),
		.wr_en   (ent_we),
		.wr_addr (ent_wa),
		.wr_data ({key_q, now_q}),
		.rd_addr (rd_addr),
		.rd_data (ent_rd)
	);

	fte_ram #(.WIDTH(IW), .DEPTH(TABLE_ENTRIES)) u_newer (
		.clk     (clk),
		.wr_en   (nw_we),
		.wr_addr (nw_wa),
		.wr_data (nw_wd),
		.rd_addr (rd_addr),
		.rd_data (nw_rd)
	);

	fte_ram #(.WIDTH(IW), .DEPTH(TABLE_ENTRIES)) u_older (
		.clk     (clk),
		.wr_en   (od_we),
		.wr_addr (od_wa),
		.wr_data (od_wd),
		.rd_addr (rd_addr),
		.rd_data (od_rd)
	);

	// stack of released slots, top always read
	fte_ram #(.WIDTH(IW), .DEPTH(TABLE_ENTRIES)) u_free (
		.clk     (clk),
		.wr_en   (stk_we),
		.wr_addr (sp_q[IW-1:0]),
		.wr_data (e_q),
		.rd_addr (IW'(sp_q - (IW+1)'(1))),
		.rd_data (stk_rd)
	);

	a_occ_range: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q <= N_CNT)
		else $error("occupancy above table size");

	a_slot_balance: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q == fresh_q - sp_q)
		else $error("slot accounting out of balance");

	a_insert_room: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_INSERT |-> !full)
		else $error("insert into a full table");

	a_one_pop: assert property (@(posedge clk) disable iff (!arst_n)
		(work_valid && work_ready) |=> state_q == ST_EXP_RD)
		else $error("item taken without starting expiry");

endmodule

[rtl/flow_table_idle_expiry_core.sv]
// flow_table_idle_expiry_core: top level of the flow table with idle expiry
// depends on fte_pkg, fte_front, fte_fifo, fte_back
//
// Usage:
// - in channel (in_valid/in_ready/in_data) takes one packet word: addresses,
//   ports and length. out channel (out_valid/out_ready/out_data) returns one
//   result word per packet, in order: new_flow, table_full, expired_count
//   and arrival_time.
// - cfg_wr_en/cfg_wr_data write idle_timeout_ns; write only while idle.
// - the front computes the time step in a two stage pipeline and feeds a
//   two word queue, so it keeps taking packets while the engine works.
// - the engine handles one packet at a time: it expires X flows, one per
//   cycle, then walks P flows in age order before the match (all of them
//   on a miss), one per cycle through the entry and link ram read port;
//   a hit makes the entry newest; a miss inserts unless the table is full.
// - reset empties the table at once; no clearing pass is needed.
// - when out_ready is low the result register holds; the engine stops at
//   its next result and the queue and front fill, then in_ready drops.

module flow_table_idle_expiry_core
	import fte_pkg::*;
#(
	parameter int TABLE_ENTRIES = 4096
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_wr_en,
	input  logic [TIMEOUT_W-1:0] cfg_wr_data,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  fte_in_t              in_data,
	output logic                 out_valid,
	input  logic                 out_ready,
	output fte_out_t             out_data
);

	logic      fr_valid;
	logic      fr_ready;
	fte_work_t fr_data;
	logic      bk_valid;
	logic      bk_ready;
	fte_work_t bk_data;

	fte_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_data    (in_data),
		.work_valid (fr_valid),
		.work_ready (fr_ready),
		.work_data  (fr_data)
	);

	fte_fifo #(.WIDTH($bits(fte_work_t))) u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (fr_valid),
		.wr_ready (fr_ready),
		.wr_data  (fr_data),
		.rd_valid (bk_valid),
		.rd_ready (bk_ready),
		.rd_data  (bk_data)
	);

	fte_back #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.work_valid  (bk_valid),
		.work_ready  (bk_ready),
		.work_data   (bk_data),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_data    (out_data)
	);

endmodule
